>>> sv/mtep_pkg.sv
// Shared types, constants and decode helpers for the MIDI track event parser.
package mtep_pkg;

  localparam int MAX_VLQ_BYTES   = 4;
  localparam int DATA_WORD_BYTES = 4;

  localparam int DELTA_W = 28;

  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [3:0] NIBBLE_SYS   = 4'hF;
  localparam logic [3:0] NIBBLE_PROG  = 4'hC;
  localparam logic [3:0] NIBBLE_CPRS  = 4'hD;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] META_NAME    = 8'h03;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_KEYSIG  = 8'h59;

  typedef enum logic [3:0] {
    KIND_NOTE_OFF      = 4'd0,
    KIND_NOTE_ON       = 4'd1,
    KIND_POLY_PRESSURE = 4'd2,
    KIND_CONTROL       = 4'd3,
    KIND_PROGRAM       = 4'd4,
    KIND_CHAN_PRESSURE = 4'd5,
    KIND_PITCH_BEND    = 4'd6,
    KIND_SYSEX         = 4'd7,
    KIND_END           = 4'd8,
    KIND_NAME          = 4'd9,
    KIND_TEMPO         = 4'd10,
    KIND_TIMESIG       = 4'd11,
    KIND_KEYSIG        = 4'd12,
    KIND_META          = 4'd13,
    KIND_VLQ_ERR       = 4'd14,
    KIND_TRUNC         = 4'd15
  } kind_t;

  // Classified input word, as it travels from the front queue to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_status;
    logic       is_meta;
    logic       is_system;
    logic       one_data;
    kind_t      meta_kind;
  } byte_cls_t;

  typedef struct packed {
    kind_t                kind;
    logic [DELTA_W-1:0]   delta_time;
    logic [7:0]           status_byte;
    logic [3:0]           channel_number;
    logic [7:0]           meta_type;
    logic [2:0]           data_count;
    logic [31:0]          data_word;
    logic [DELTA_W-1:0]   payload_length;
    logic                 track_done;
  } result_t;

  function automatic kind_t chan_kind(input logic [7:0] status);
    return kind_t'({1'b0, status[6:4]});
  endfunction

  function automatic kind_t meta_kind(input logic [7:0] mtype);
    kind_t k;
    priority case (mtype)
      META_END:     k = KIND_END;
      META_NAME:    k = KIND_NAME;
      META_TEMPO:   k = KIND_TEMPO;
      META_TIMESIG: k = KIND_TIMESIG;
      META_KEYSIG:  k = KIND_KEYSIG;
      default:      k = KIND_META;
    endcase
    return k;
  endfunction

endpackage

>>> sv/mtep_front.sv
// Front end: classifies incoming bytes and holds them in a two-word queue.
module mtep_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                start_track,
  output logic                head_valid,
  output mtep_pkg::byte_cls_t head,
  input  logic                head_take
);

  mtep_pkg::byte_cls_t slots [2];
  mtep_pkg::byte_cls_t cls;
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                wr_en;

  always_comb begin
    cls.data      = data_byte;
    cls.start     = start_track;
    cls.is_status = data_byte[7];
    cls.is_meta   = data_byte == mtep_pkg::STATUS_META;
    cls.is_system = data_byte[7:4] == mtep_pkg::NIBBLE_SYS;
    cls.one_data  = data_byte[7:4] == mtep_pkg::NIBBLE_PROG ||
                    data_byte[7:4] == mtep_pkg::NIBBLE_CPRS;
    cls.meta_kind = mtep_pkg::meta_kind(data_byte);
  end

  assign full       = count == 2'd2;
  assign wr_en      = push && !full;
  assign head_valid = count != 2'd0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (head_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, head_take};
    end
  end

`ifndef SYNTH
  a_no_take_empty: assert property (@(posedge clk) disable iff (rst)
    head_take |-> head_valid)
    else $error("front queue taken while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("front queue count out of range");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !head_take) |=> full)
    else $error("front queue lost a word while full");
`endif

endmodule

>>> sv/mtep_core.sv
// Parser back end: one classified byte per cycle through the event state machine while res_space is high.
module mtep_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         track_length,
  input  logic                in_valid,
  input  mtep_pkg::byte_cls_t in_item,
  output logic                in_take,
  input  logic                res_space,
  output logic                res_valid,
  output mtep_pkg::result_t   res
);

  localparam logic [2:0] VLQ_LIMIT  = 3'(mtep_pkg::MAX_VLQ_BYTES);
  localparam logic [3:0] PACK_LIMIT = 4'(mtep_pkg::DATA_WORD_BYTES);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_CHDATA,
    PH_METATYPE,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    phase_t                        phase;
    logic [mtep_pkg::DELTA_W-1:0]  acc;
    logic [2:0]                    vcnt;
    logic [mtep_pkg::DELTA_W-1:0]  held;
    logic [7:0]                    meta;
    mtep_pkg::kind_t               mkind;
    logic [mtep_pkg::DELTA_W-1:0]  br;
    logic [31:0]                   pd;
    logic [3:0]                    pc;
    logic [7:0]                    es;
  } ev_t;

  localparam ev_t EV_CLEAR = '{
    phase: PH_DELTA, acc: '0, vcnt: '0, held: '0, meta: '0,
    mkind: mtep_pkg::KIND_META, br: '0, pd: '0, pc: '0, es: '0
  };

  ev_t         ev;
  logic [7:0]  rs;
  logic        rs_one;
  logic [31:0] offset;
  logic        ended;

  ev_t         ev_next;
  logic [7:0]  rs_next;
  logic        rs_one_next;
  logic [31:0] offset_next;
  logic        ended_next;

  ev_t         cur;
  logic [7:0]  cur_rs;
  logic [31:0] cur_offset;
  logic        cur_ended;

  logic [mtep_pkg::DELTA_W-1:0] acc7;
  logic [2:0]                   cnt1;
  logic [31:0]                  pk_pd;
  logic [3:0]                   pk_pc;
  logic [mtep_pkg::DELTA_W-1:0] br_dec;
  logic                         is_name;
  mtep_pkg::kind_t              pay_kind;
  logic                         hit;
  logic                         idle;
  mtep_pkg::result_t            res_c;

  function automatic mtep_pkg::result_t mk(input ev_t e, input mtep_pkg::kind_t k,
                                           input logic [3:0] cnt, input logic [31:0] w,
                                           input logic done);
    mtep_pkg::result_t r;
    r.kind           = k;
    r.delta_time     = e.held;
    r.status_byte    = e.es;
    r.channel_number = (e.es[7] && e.es[7:4] != mtep_pkg::NIBBLE_SYS) ? e.es[3:0] : 4'd0;
    r.meta_type      = e.meta;
    r.data_count     = cnt[2:0];
    r.data_word      = w;
    r.payload_length = e.acc;
    r.track_done     = done;
    return r;
  endfunction

  assign in_take = in_valid && res_space;

  always_comb begin
    // start of track clears the event, running status and offset first
    cur        = in_item.start ? EV_CLEAR : ev;
    cur_rs     = in_item.start ? 8'd0 : rs;
    cur_offset = in_item.start ? 32'd0 : offset;
    cur_ended  = in_item.start ? 1'b0 : ended;

    acc7     = {cur.acc[mtep_pkg::DELTA_W-8:0], in_item.data[6:0]};
    cnt1     = cur.vcnt + 3'd1;
    pk_pd    = (cur.pc < PACK_LIMIT) ? {cur.pd[23:0], in_item.data} : cur.pd;
    pk_pc    = (cur.pc < PACK_LIMIT) ? cur.pc + 4'd1 : cur.pc;
    br_dec   = cur.br - 28'd1;
    is_name  = cur.es == mtep_pkg::STATUS_META && cur.mkind == mtep_pkg::KIND_NAME;
    pay_kind = (cur.es != mtep_pkg::STATUS_META) ? mtep_pkg::KIND_SYSEX : cur.mkind;

    ev_next     = cur;
    rs_next     = cur_rs;
    rs_one_next = rs_one;
    offset_next = cur_offset;
    ended_next  = cur_ended;
    hit         = 1'b0;
    idle        = 1'b0;
    res_c       = '0;

    if (!cur_ended && cur_offset < track_length) begin
      offset_next = cur_offset + 32'd1;
      unique case (cur.phase)
        PH_DELTA: begin
          if (in_item.data[7]) begin
            ev_next.acc  = acc7;
            ev_next.vcnt = cnt1;
            if (cnt1 >= VLQ_LIMIT) begin
              ev_next.held = '0;
              res_c        = mk(ev_next, mtep_pkg::KIND_VLQ_ERR, cur.pc, cur.pd, 1'b1);
              hit          = 1'b1;
              ended_next   = 1'b1;
            end
          end else begin
            ev_next.vcnt  = '0;
            ev_next.held  = acc7;
            ev_next.acc   = '0;
            ev_next.phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (in_item.is_status) begin
            ev_next.es = in_item.data;
            if (in_item.is_meta) begin
              rs_next       = 8'd0;
              ev_next.phase = PH_METATYPE;
            end else if (in_item.is_system) begin
              rs_next       = 8'd0;
              ev_next.phase = PH_LEN;
            end else begin
              rs_next       = in_item.data;
              rs_one_next   = in_item.one_data;
              ev_next.br    = in_item.one_data ? 28'd1 : 28'd2;
              ev_next.phase = PH_CHDATA;
            end
          end else if (cur_rs != 8'd0) begin
            // running status: this byte is the first data byte
            ev_next.es = cur_rs;
            ev_next.pd = pk_pd;
            ev_next.pc = pk_pc;
            if (rs_one) begin
              res_c   = mk(ev_next, mtep_pkg::chan_kind(cur_rs), pk_pc, pk_pd, 1'b0);
              hit     = 1'b1;
              ev_next = EV_CLEAR;
            end else begin
              ev_next.br    = 28'd1;
              ev_next.phase = PH_CHDATA;
            end
          end
        end
        PH_CHDATA: begin
          ev_next.pd = pk_pd;
          ev_next.pc = pk_pc;
          ev_next.br = br_dec;
          if (br_dec == '0) begin
            res_c   = mk(ev_next, mtep_pkg::chan_kind(cur.es), pk_pc, pk_pd, 1'b0);
            hit     = 1'b1;
            ev_next = EV_CLEAR;
          end
        end
        PH_METATYPE: begin
          ev_next.meta  = in_item.data;
          ev_next.mkind = in_item.meta_kind;
          ev_next.phase = PH_LEN;
        end
        PH_LEN: begin
          ev_next.acc  = acc7;
          ev_next.vcnt = cnt1;
          if (in_item.data[7]) begin
            if (cnt1 >= VLQ_LIMIT) begin
              res_c      = mk(ev_next, mtep_pkg::KIND_VLQ_ERR, cur.pc, cur.pd, 1'b1);
              hit        = 1'b1;
              ended_next = 1'b1;
            end
          end else begin
            ev_next.vcnt = '0;
            ev_next.br   = acc7;
            if (acc7 == '0) begin
              hit = 1'b1;
              if (is_name) begin
                res_c = mk(ev_next, mtep_pkg::KIND_NAME, 4'd0, 32'd0, 1'b0);
              end else begin
                res_c = mk(ev_next, pay_kind, cur.pc, cur.pd,
                           pay_kind == mtep_pkg::KIND_END);
                ended_next = pay_kind == mtep_pkg::KIND_END;
              end
              ev_next = EV_CLEAR;
            end else begin
              ev_next.phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          ev_next.pd = pk_pd;
          ev_next.pc = pk_pc;
          ev_next.br = br_dec;
          if (is_name) begin
            res_c = mk(ev_next, mtep_pkg::KIND_NAME, 4'd1, {24'd0, in_item.data}, 1'b0);
            hit   = 1'b1;
            if (br_dec == '0) begin
              ev_next = EV_CLEAR;
            end
          end else if (br_dec == '0) begin
            res_c      = mk(ev_next, pay_kind, pk_pc, pk_pd, pay_kind == mtep_pkg::KIND_END);
            hit        = 1'b1;
            ended_next = pay_kind == mtep_pkg::KIND_END;
            ev_next    = EV_CLEAR;
          end
        end
        default: begin
          ev_next = EV_CLEAR;
        end
      endcase

      // last byte of the chunk: close a finished event, else flag truncation
      if (!ended_next && offset_next == track_length) begin
        idle = ev_next.phase == PH_DELTA && ev_next.vcnt == '0;
        if (hit && idle) begin
          res_c.track_done = 1'b1;
        end else begin
          res_c = mk(ev_next, mtep_pkg::KIND_TRUNC, ev_next.pc, ev_next.pd, 1'b1);
          hit   = 1'b1;
        end
        ended_next = 1'b1;
      end
    end
  end

  assign res_valid = in_take && hit;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev     <= EV_CLEAR;
      rs     <= 8'd0;
      rs_one <= 1'b0;
      offset <= 32'd0;
      ended  <= 1'b0;
    end else if (in_take) begin
      ev     <= ev_next;
      rs     <= rs_next;
      rs_one <= rs_one_next;
      offset <= offset_next;
      ended  <= ended_next;
    end
  end

`ifndef SYNTH
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_take && ended && !in_item.start) |-> !res_valid)
    else $error("result after end of track");
  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    ev.pc <= PACK_LIMIT)
    else $error("packed count past data word size");
  a_vlq_bound: assert property (@(posedge clk) disable iff (rst)
    !ended |-> ev.vcnt < VLQ_LIMIT)
    else $error("VLQ byte count past limit on a live track");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.track_done) |=> ended)
    else $error("track_done given but track not ended");
`endif

endmodule

>>> sv/mtep_outq.sv
// Result queue: two-word register queue that feeds the result ports.
module mtep_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  mtep_pkg::result_t wr_data,
  output logic              space,
  output logic              empty,
  input  logic              pop,
  output mtep_pkg::result_t head
);

  mtep_pkg::result_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              rd_en;

  assign space = count != 2'd2;
  assign empty = count == 2'd0;
  assign rd_en = pop && !empty;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, wr_valid} - {1'b0, rd_en};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> space)
    else $error("result queue written while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");
  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(head))
    else $error("result head changed while waiting");
`endif

endmodule

>>> sv/midi_track_event_parser.sv
// Top level of the MIDI track event parser: front queue, parser core, result queue.
//
// Bytes of a track chunk payload enter through push/full; a byte is taken at a
// clock edge with push high and full low. start_track marks the first byte of a
// track and clears running status, the byte offset and any event in progress.
// Results leave through empty/pop: the oldest result sits on the result ports
// while empty is low and is taken at an edge with pop high.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes track_length, the chunk
// payload size; cfg_ready is always high. Write it only while the block is idle.
// Throughput is one byte per cycle while full is low; the core updates its event
// state for one byte each cycle while the result queue has space. A taken byte
// is registered in the front queue and its result, if any, in the result queue.
// A two-word queue sits on each side of the core. When pop stays low the result
// queue fills, the core stops taking bytes, and the front queue then raises
// full; no word is lost or repeated.
// Reset clears all control state and sets track_length to zero, so bytes are
// ignored until a length is written.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        start_track,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind,
  output logic [27:0] delta_time,
  output logic [7:0]  status_byte,
  output logic [3:0]  channel_number,
  output logic [7:0]  meta_type,
  output logic [2:0]  data_count,
  output logic [31:0] data_word,
  output logic [27:0] payload_length,
  output logic        track_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]         track_length;
  logic                head_valid;
  mtep_pkg::byte_cls_t head_item;
  logic                head_take;
  logic                res_space;
  logic                res_valid;
  mtep_pkg::result_t   res_core;
  mtep_pkg::result_t   res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      track_length <= cfg_data;
    end
  end

  mtep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .start_track (start_track),
    .head_valid  (head_valid),
    .head        (head_item),
    .head_take   (head_take)
  );

  mtep_core u_core (
    .clk          (clk),
    .rst          (rst),
    .track_length (track_length),
    .in_valid     (head_valid),
    .in_item      (head_item),
    .in_take      (head_take),
    .res_space    (res_space),
    .res_valid    (res_valid),
    .res          (res_core)
  );

  mtep_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (res_core),
    .space    (res_space),
    .empty    (empty),
    .pop      (pop),
    .head     (res_head)
  );

  assign kind           = res_head.kind;
  assign delta_time     = res_head.delta_time;
  assign status_byte    = res_head.status_byte;
  assign channel_number = res_head.channel_number;
  assign meta_type      = res_head.meta_type;
  assign data_count     = res_head.data_count;
  assign data_word      = res_head.data_word;
  assign payload_length = res_head.payload_length;
  assign track_done     = res_head.track_done;

endmodule
